// File: rtl/core/srtk_pkg.sv
// Shared types, constants and codes for the scan result top-k table.
`timescale 1ns / 1ps
`default_nettype none
package srtk_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int RD_IDX_W = 4;
	localparam int CMP_W = (CNT_W > RD_IDX_W) ? CNT_W : RD_IDX_W;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_UPDATED  = 3'd0,
		ST_APPENDED = 3'd1,
		ST_REPLACED = 3'd2,
		ST_DROPPED  = 3'd3,
		ST_READ_OK  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_DECIDE,
		S_COUNT,
		S_SHIFT,
		S_READ,
		S_FETCH
	} seq_state_t;

	typedef struct packed {
		logic              opcode;
		logic [63:0]       name_word0;
		logic [63:0]       name_word1;
		logic [63:0]       name_word2;
		logic [63:0]       name_word3;
		logic [47:0]       station_mac;
		logic [7:0]        radio_channel;
		logic signed [7:0] signal_strength;
		logic [1:0]        freq_band;
		logic [3:0]        security_kind;
		logic [1:0]        frame_protection;
		logic [3:0]        read_index;
	} cmd_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [4:0]        entry_count;
		logic [63:0]       out_name_word0;
		logic [63:0]       out_name_word1;
		logic [63:0]       out_name_word2;
		logic [63:0]       out_name_word3;
		logic [47:0]       out_mac;
		logic [7:0]        out_channel;
		logic signed [7:0] out_strength;
		logic [1:0]        out_band;
		logic [3:0]        out_security;
		logic [1:0]        out_protection;
	} res_t;

	// One stored network, kept at a fixed slot for its whole life.
	typedef struct packed {
		logic [63:0]       name0;
		logic [63:0]       name1;
		logic [63:0]       name2;
		logic [63:0]       name3;
		logic [47:0]       mac;
		logic [7:0]        channel;
		logic signed [7:0] strength;
		logic [1:0]        band;
		logic [3:0]        security;
		logic [1:0]        protection;
	} entry_t;

	// Move the entry at rank p to rank q and close the gap.
	typedef struct packed {
		logic              en;
		idx_t              p;
		idx_t              q;
		idx_t              slot;
		logic signed [7:0] strength;
	} rank_upd_t;

endpackage
`default_nettype wire

// File: rtl/core/srtk_ram.sv
// Slot-addressed payload memory for the stored networks.
`timescale 1ns / 1ps
`default_nettype none
module srtk_ram
	import srtk_pkg::*;
(
	input  logic   clk,
	input  logic   we,
	input  idx_t   waddr,
	input  entry_t wdata,
	input  idx_t   raddr,
	output entry_t rdata
);

	entry_t mem [TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/core/srtk_rank.sv
// Rank list: slot number and strength of each entry in descending strength order.
`timescale 1ns / 1ps
`default_nettype none
module srtk_rank
	import srtk_pkg::*;
(
	input  logic              clk,
	input  rank_upd_t         upd,
	input  idx_t              rd_idx,
	output idx_t              rd_slot,
	output logic signed [7:0] rd_str,
	output idx_t              last_slot,
	output logic signed [7:0] last_str
);

	idx_t              ord_q [TABLE_ENTRIES];
	logic signed [7:0] str_q [TABLE_ENTRIES];
	idx_t              ord_nxt [TABLE_ENTRIES];
	logic signed [7:0] str_nxt [TABLE_ENTRIES];

	assign rd_slot   = ord_q[rd_idx];
	assign rd_str    = str_q[rd_idx];
	assign last_slot = ord_q[TABLE_ENTRIES-1];
	assign last_str  = str_q[TABLE_ENTRIES-1];

	// Each rank takes its own value, a neighbour's, or the moved entry.
	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			ord_nxt[i] = ord_q[i];
			str_nxt[i] = str_q[i];
			if (idx_t'(i) == upd.q) begin
				ord_nxt[i] = upd.slot;
				str_nxt[i] = upd.strength;
			end else if (upd.q <= upd.p && idx_t'(i) > upd.q && idx_t'(i) <= upd.p) begin
				ord_nxt[i] = ord_q[(i == 0) ? 0 : i - 1];
				str_nxt[i] = str_q[(i == 0) ? 0 : i - 1];
			end else if (upd.q > upd.p && idx_t'(i) >= upd.p && idx_t'(i) < upd.q) begin
				ord_nxt[i] = ord_q[(i == TABLE_ENTRIES - 1) ? i : i + 1];
				str_nxt[i] = str_q[(i == TABLE_ENTRIES - 1) ? i : i + 1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				ord_q[i] <= ord_nxt[i];
				str_q[i] <= str_nxt[i];
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/scan_result_top_k_table_core.sv
// Top level: sequencer, shared strength comparator and result register.
//
//   port     | dir | handshake                  | content
//   cmd      | in  | taken when start && !busy  | opcode, name words, mac, radio fields
//   result   | out | valid for one cycle: done  | status, entry_count, read entry fields
//
// A read passes through S_READ and then S_FETCH before done; it ends in S_READ when
// the index is past the count. An insert runs a name search and a rank count, each
// stepping through the rank list one entry per cycle over its single read port.
// Reset empties the table at once; no clearing pass. done rises in the first cycle
// with busy low and the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none
module scan_result_top_k_table_core
	import srtk_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output res_t result
);

	seq_state_t state_q, state_d;
	cmd_t       cmd_q;
	cnt_t       count_q, k_q;
	idx_t       k_idx, p_q, q_q, slot_q, rank_s1, slot_s1;
	logic       pend_s1, found_q, rd_ok_q;
	status_t    status_q;
	logic       done_q, finish;
	res_t       result_q, res_d;

	idx_t              rank_rd_slot, rank_last_slot;
	logic signed [7:0] rank_rd_str, rank_last_str;
	rank_upd_t         upd;

	logic   ram_we;
	entry_t ram_wdata, ram_rdata;

	logic signed [7:0] cmp_a;
	logic              cmp_lt, cmp_eq;

	logic    issue, hit, table_full, count_last, lower, inc;
	status_t dec_status;
	idx_t    dec_p, dec_slot;

	assign k_idx = k_q[IDX_W-1:0];
	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign result = result_q;

	srtk_rank u_rank (
		.clk      (clk),
		.upd      (upd),
		.rd_idx   (k_idx),
		.rd_slot  (rank_rd_slot),
		.rd_str   (rank_rd_str),
		.last_slot(rank_last_slot),
		.last_str (rank_last_str)
	);

	assign ram_wdata = '{
		name0:      cmd_q.name_word0,
		name1:      cmd_q.name_word1,
		name2:      cmd_q.name_word2,
		name3:      cmd_q.name_word3,
		mac:        cmd_q.station_mac,
		channel:    cmd_q.radio_channel,
		strength:   cmd_q.signal_strength,
		band:       cmd_q.freq_band,
		security:   cmd_q.security_kind,
		protection: cmd_q.frame_protection
	};

	srtk_ram u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(dec_slot),
		.wdata(ram_wdata),
		.raddr(rank_rd_slot),
		.rdata(ram_rdata)
	);

	// Shared signed comparator: weakest entry when deciding, current rank otherwise.
	assign cmp_a  = (state_q == S_DECIDE) ? rank_last_str : rank_rd_str;
	assign cmp_lt = (cmp_a < cmd_q.signal_strength);
	assign cmp_eq = (cmp_a == cmd_q.signal_strength);

	assign issue = (k_q < count_q);
	assign hit = pend_s1
		&& ram_rdata.name0 == cmd_q.name_word0 && ram_rdata.name1 == cmd_q.name_word1
		&& ram_rdata.name2 == cmd_q.name_word2 && ram_rdata.name3 == cmd_q.name_word3;
	assign table_full = (count_q == cnt_t'(TABLE_ENTRIES));
	assign count_last = (cnt_t'(k_q + 1'b1) == count_q);

	// Entries above the moved one count when not weaker, those below only when stronger.
	assign lower = (k_q < cnt_t'(p_q));
	assign inc = (k_q != cnt_t'(p_q)) && (lower ? !cmp_lt : (!cmp_lt && !cmp_eq));

	always_comb begin
		dec_status = ST_DROPPED;
		dec_p = p_q;
		dec_slot = slot_q;
		if (found_q) begin
			dec_status = ST_UPDATED;
		end else if (!table_full) begin
			dec_status = ST_APPENDED;
			dec_p = count_q[IDX_W-1:0];
			dec_slot = count_q[IDX_W-1:0];
		end else if (cmp_lt) begin
			dec_status = ST_REPLACED;
			dec_p = idx_t'(TABLE_ENTRIES - 1);
			dec_slot = rank_last_slot;
		end
	end

	assign ram_we = (state_q == S_DECIDE) && (dec_status != ST_DROPPED);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = (cmd.opcode == OP_READ) ? S_READ : S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (hit || (!issue && !pend_s1)) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: state_d = (dec_status == ST_DROPPED) ? S_IDLE : S_COUNT;
			S_COUNT: begin
				if (count_last) begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: state_d = S_IDLE;
			S_READ:  state_d = rd_ok_q ? S_FETCH : S_IDLE;
			S_FETCH: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		finish = 1'b0;
		res_d = '0;
		res_d.entry_count = 5'(count_q);
		upd = '{en: 1'b0, p: p_q, q: q_q, slot: slot_q, strength: cmd_q.signal_strength};
		unique case (state_q)
			S_DECIDE: begin
				finish = (dec_status == ST_DROPPED);
				res_d.status = ST_DROPPED;
			end
			S_SHIFT: begin
				finish = 1'b1;
				upd.en = 1'b1;
				res_d.status = status_q;
			end
			S_READ: begin
				finish = !rd_ok_q;
				res_d.status = ST_DROPPED;
			end
			S_FETCH: begin
				finish = 1'b1;
				res_d.status = ST_READ_OK;
				res_d.out_name_word0 = ram_rdata.name0;
				res_d.out_name_word1 = ram_rdata.name1;
				res_d.out_name_word2 = ram_rdata.name2;
				res_d.out_name_word3 = ram_rdata.name3;
				res_d.out_mac = ram_rdata.mac;
				res_d.out_channel = ram_rdata.channel;
				res_d.out_strength = ram_rdata.strength;
				res_d.out_band = ram_rdata.band;
				res_d.out_security = ram_rdata.security;
				res_d.out_protection = ram_rdata.protection;
			end
			default: begin
				finish = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= finish;
			pend_s1 <= (state_q == S_SEARCH) && issue && !hit;
			if (state_q == S_DECIDE && dec_status == ST_APPENDED) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_q <= cmd;
					found_q <= 1'b0;
					k_q <= (cmd.opcode == OP_READ) ? cnt_t'(cmd.read_index) : '0;
					rd_ok_q <= (CMP_W'(cmd.read_index) < CMP_W'(count_q));
				end
			end
			S_SEARCH: begin
				if (issue) begin
					k_q <= k_q + 1'b1;
				end
				rank_s1 <= k_idx;
				slot_s1 <= rank_rd_slot;
				if (hit) begin
					found_q <= 1'b1;
					p_q <= rank_s1;
					slot_q <= slot_s1;
				end
			end
			S_DECIDE: begin
				p_q <= dec_p;
				slot_q <= dec_slot;
				status_q <= dec_status;
				k_q <= '0;
				q_q <= '0;
			end
			S_COUNT: begin
				k_q <= k_q + 1'b1;
				q_q <= q_q + idx_t'(inc);
			end
			default: begin
				k_q <= k_q;
			end
		endcase
		if (finish) begin
			result_q <= res_d;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(TABLE_ENTRIES))
		else $error("entry count beyond table size");

	a_done_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results from one request");

	a_rank_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COUNT) |-> (cnt_t'(q_q) <= k_q))
		else $error("new rank exceeds entries scanned");

endmodule
`default_nettype wire
